### src/assert_macros.svh
// Assertion macros used by the light controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define PHLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define PHLC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### src/phlc_pkg.sv
// Types, constants and the off-timer step of the pushbutton light controller
package phlc_pkg;

	localparam int unsigned CH       = 4;
	localparam int unsigned CH_IDX_W = 2;
	localparam int unsigned REG_W    = 13;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] SECOND_AT  = 6'd8;
	localparam logic [CNT_W-1:0] ALL_OFF_AT = 6'd35;
	localparam logic [CNT_W-1:0] RANDOM_AT  = 6'd50;
	localparam logic [REG_W-1:0] RANDOM_PRESET = 13'd6000;
	localparam logic [REG_W:0]   WARN_OFF_BEFORE = 14'd100;
	localparam logic [REG_W:0]   WARN_ON_BEFORE  = 14'd95;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STAIR_CH0    = 3'd0,
		REG_STAIR_CH2    = 3'd1,
		REG_HOLD_ON_CH0  = 3'd2,
		REG_HOLD_ON_CH2  = 3'd3,
		REG_HOLD_OFF_CH1 = 3'd4,
		REG_HOLD_OFF_CH3 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] stair_ch0;
		logic [REG_W-1:0] stair_ch2;
		logic [REG_W-1:0] hold_on_ch0;
		logic [REG_W-1:0] hold_on_ch2;
		logic [REG_W-1:0] hold_off_ch1;
		logic [REG_W-1:0] hold_off_ch3;
	} cfg_t;

	typedef struct packed {
		logic [CH-1:0]             lights;
		logic [CH-1:0][CNT_W-1:0]  cnt_a;
		logic [CH-1:0][CNT_W-1:0]  cnt_b;
		logic [CH-1:0][CNT_W-1:0]  cnt_c;
		logic [CH-1:0]             was_on;
		logic [REG_W-1:0]          stair_ch0;
		logic [REG_W-1:0]          stair_ch2;
		logic [REG_W-1:0]          hold_on_ch0;
		logic [REG_W-1:0]          hold_on_ch2;
		logic [REG_W-1:0]          hold_off_ch1;
		logic [REG_W-1:0]          hold_off_ch3;
	} state_t;

	typedef struct packed {
		logic [REG_W-1:0] count;
		logic [CH-1:0]    lamps;
	} timer_res_t;

	function automatic timer_res_t timer_step(input logic [REG_W-1:0] count,
			input logic [REG_W-1:0] period, input logic [CH-1:0] lamps,
			input logic [CH_IDX_W-1:0] target);
		logic [REG_W:0] c;
		logic [REG_W:0] p;
		timer_res_t r;
		c = {1'b0, count} + 14'd1;
		p = {1'b0, period};
		r.count = count;
		r.lamps = lamps;
		if (count != '0) begin
			if (c >= p) begin
				r.lamps[target] = 1'b0;
				r.count = '0;
			end else begin
				if (p >= WARN_ON_BEFORE && c == p - WARN_ON_BEFORE) begin
					r.lamps[target] = 1'b1;
				end else if (p >= WARN_OFF_BEFORE && c == p - WARN_OFF_BEFORE) begin
					r.lamps[target] = 1'b0;
				end
				r.count = c[REG_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

### src/pushbutton_hold_light_controller_core.sv
// Top level of the pushbutton hold light controller
//
// Tick channel (tick_valid/tick_ready, buttons): one word per 100 ms tick
// with the four button levels. Light channel (light_valid/light_ready,
// lights, random_request): one word per tick with the four light states
// and the random-mode request flag.
// The tick word is registered, the whole channel and timer update runs
// on it combinationally, and the result lands in the output register
// once that register is free.
// One tick word is taken every cycle while the output is not held by
// light_ready; the throughput is set by the single state update.
// While light_ready is low the output register holds its word and the
// input register can still take one more tick word; after that
// tick_ready drops until the receiver drains.
// The six timing registers are written through cfg_we/cfg_index/cfg_data
// and take effect from the next tick; unused indexes are dropped.
// Reset clears all lights, hold counters and timers and loads the
// register defaults; no word is pending after reset.
module pushbutton_hold_light_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_ready,
	input  logic [3:0]                      buttons,
	output logic                            light_valid,
	input  logic                            light_ready,
	output logic [3:0]                      lights,
	output logic                            random_request,
	input  logic                            cfg_we,
	input  logic [phlc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phlc_pkg::REG_W-1:0]      cfg_data
);
	import phlc_pkg::*;

	`include "assert_macros.svh"

	cfg_t        cfg_q;
	state_t      st_q;
	state_t      st_nx;
	logic        valid_s1;
	logic [3:0]  buttons_s1;
	logic        out_valid_q;
	logic [3:0]  lights_q;
	logic        random_request_q;
	logic        random_nx;
	logic        advance;

	assign advance    = valid_s1 && (!out_valid_q || light_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stair_ch0    <= 13'd7000;
			cfg_q.stair_ch2    <= 13'd4000;
			cfg_q.hold_on_ch0  <= 13'd5000;
			cfg_q.hold_on_ch2  <= 13'd4000;
			cfg_q.hold_off_ch1 <= 13'd4000;
			cfg_q.hold_off_ch3 <= 13'd2000;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STAIR_CH0:    cfg_q.stair_ch0    <= cfg_data;
				REG_STAIR_CH2:    cfg_q.stair_ch2    <= cfg_data;
				REG_HOLD_ON_CH0:  cfg_q.hold_on_ch0  <= cfg_data;
				REG_HOLD_ON_CH2:  cfg_q.hold_on_ch2  <= cfg_data;
				REG_HOLD_OFF_CH1: cfg_q.hold_off_ch1 <= cfg_data;
				REG_HOLD_OFF_CH3: cfg_q.hold_off_ch3 <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_ready) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			buttons_s1 <= buttons;
		end
	end

	phlc_tick u_tick (
		.st             (st_q),
		.cfg            (cfg_q),
		.buttons        (buttons_s1),
		.nx             (st_nx),
		.random_request (random_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (light_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lights_q         <= st_nx.lights;
			random_request_q <= random_nx;
		end
	end

	assign light_valid    = out_valid_q;
	assign lights         = lights_q;
	assign random_request = random_request_q;

	`PHLC_ASSERT(a_result_from_input, $rose(out_valid_q) |-> $past(valid_s1), "result without input word")
	`PHLC_ASSERT(a_state_holds, !advance |=> $stable(st_q), "state changed without a word")
	`PHLC_ASSERT(a_counters_track, st_q.cnt_b == st_q.cnt_c, "hold counters out of step")
	`PHLC_NEVER(a_random_cleared, st_q.cnt_c[0] >= RANDOM_AT || st_q.cnt_c[1] >= RANDOM_AT || st_q.cnt_c[2] >= RANDOM_AT || st_q.cnt_c[3] >= RANDOM_AT, "hold counter past random threshold")

endmodule

### src/phlc_tick.sv
// Next-state logic for one tick: button channels in order, then the off-timer banks
module phlc_tick (
	input  phlc_pkg::state_t    st,
	input  phlc_pkg::cfg_t      cfg,
	input  logic [3:0]          buttons,
	output phlc_pkg::state_t    nx,
	output logic                random_request
);
	import phlc_pkg::*;

	always_comb begin
		logic [CH_IDX_W-1:0] idx;
		logic                on;
		logic                has_stair;
		timer_res_t          t;
		nx = st;
		random_request = 1'b0;
		on = 1'b0;
		for (int i = 0; i < CH; i++) begin
			idx = CH_IDX_W'(i);
			has_stair = (idx == 2'd0) ? (cfg.stair_ch0 != '0) :
				((idx == 2'd2) ? (cfg.stair_ch2 != '0) : 1'b0);
			if (!buttons[idx]) begin
				nx.cnt_a[idx] = '0;
				nx.cnt_b[idx] = '0;
				nx.cnt_c[idx] = '0;
			end else begin
				if (nx.cnt_a[idx] == '0) begin
					on = nx.lights[idx];
					nx.cnt_a[idx] = 6'd1;
					nx.cnt_b[idx] = nx.cnt_b[idx] + 6'd1;
					nx.cnt_c[idx] = nx.cnt_c[idx] + 6'd1;
					nx.was_on[idx] = on;
					if (on) begin
						if (idx == 2'd0) nx.stair_ch0 = '0;
						if (idx == 2'd2) nx.stair_ch2 = '0;
						nx.lights[idx] = 1'b0;
					end else begin
						if (has_stair && idx == 2'd0) nx.stair_ch0 = 13'd1;
						if (has_stair && idx == 2'd2) nx.stair_ch2 = 13'd1;
						nx.lights[idx] = 1'b1;
					end
				end
				nx.cnt_a[idx] = nx.cnt_a[idx] + 6'd1;
				if (nx.cnt_a[idx] == SECOND_AT) begin
					case (idx)
						2'd0: begin
							if (!nx.was_on[idx]) begin
								if (cfg.hold_on_ch0 != '0) begin
									nx.hold_on_ch0 = 13'd1;
									nx.stair_ch0 = '0;
								end
								nx.lights[2] = 1'b1;
							end else begin
								nx.lights[2] = 1'b0;
								nx.stair_ch0 = '0;
							end
						end
						2'd1: begin
							if (nx.was_on[idx]) begin
								if (cfg.hold_off_ch1 != '0) nx.hold_off_ch1 = 13'd1;
								nx.lights[0] = 1'b1;
							end
						end
						2'd2: begin
							if (!nx.was_on[idx]) begin
								if (cfg.hold_on_ch2 != '0) begin
									nx.hold_on_ch2 = 13'd1;
									nx.stair_ch2 = '0;
								end
								nx.lights[0] = 1'b1;
							end else begin
								nx.lights[0] = 1'b0;
								nx.stair_ch2 = '0;
							end
						end
						default: begin
							if (nx.was_on[idx] && cfg.hold_off_ch3 != '0) begin
								nx.hold_off_ch3 = 13'd1;
							end
							nx.lights[0] = 1'b1;
						end
					endcase
					nx.cnt_a[idx] = nx.cnt_a[idx] + 6'd1;
				end
				if (nx.cnt_b[idx] != '0) begin
					nx.cnt_b[idx] = nx.cnt_b[idx] + 6'd1;
					if (nx.cnt_b[idx] == ALL_OFF_AT) begin
						nx.lights = '0;
						nx.stair_ch0 = '0;
						nx.stair_ch2 = '0;
					end
				end
				if (nx.cnt_c[idx] != '0) begin
					nx.cnt_c[idx] = nx.cnt_c[idx] + 6'd1;
					if (nx.cnt_c[idx] == RANDOM_AT) begin
						nx.cnt_a[idx] = '0;
						nx.cnt_b[idx] = '0;
						nx.cnt_c[idx] = '0;
						random_request = 1'b1;
						if (idx == 2'd2) nx.stair_ch2 = '0;
						nx.lights[0] = 1'b1;
						nx.stair_ch0 = RANDOM_PRESET;
					end
				end
			end
		end

		// advance the off-timers in bank order
		t = timer_step(nx.stair_ch0, cfg.stair_ch0, nx.lights, 2'd0);
		nx.stair_ch0 = t.count;
		nx.lights = t.lamps;
		t = timer_step(nx.stair_ch2, cfg.stair_ch2, nx.lights, 2'd2);
		nx.stair_ch2 = t.count;
		nx.lights = t.lamps;
		t = timer_step(nx.hold_on_ch0, cfg.hold_on_ch0, nx.lights, 2'd2);
		nx.hold_on_ch0 = t.count;
		nx.lights = t.lamps;
		t = timer_step(nx.hold_on_ch2, cfg.hold_on_ch2, nx.lights, 2'd0);
		nx.hold_on_ch2 = t.count;
		nx.lights = t.lamps;
		t = timer_step(nx.hold_off_ch1, cfg.hold_off_ch1, nx.lights, 2'd0);
		nx.hold_off_ch1 = t.count;
		nx.lights = t.lamps;
		t = timer_step(nx.hold_off_ch3, cfg.hold_off_ch3, nx.lights, 2'd0);
		nx.hold_off_ch3 = t.count;
		nx.lights = t.lamps;
	end

endmodule

### sim/tb_top.sv
// Testbench for pushbutton_hold_light_controller_core: directed and random ticks checked against a built-in predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import phlc_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int LONG_HOLD_OFF = 200;
	localparam int SETTLE_CYCLES = 6;
	localparam int TICK_GOAL     = 850;
	localparam int NO_LAMP       = -1;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CH-1:0] lights;
		logic          random_request;
	} lamp_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_ready;
	logic [CH-1:0]        buttons = '0;
	logic                 light_valid;
	logic                 light_ready = 1'b0;
	logic [CH-1:0]        lights;
	logic                 random_request;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;

	logic [REG_W-1:0] timing [REG_STAIR_CH0:REG_HOLD_OFF_CH3];
	logic [CH-1:0]    lamp_q;
	logic [CNT_W-1:0] hold_a [CH];
	logic [CNT_W-1:0] hold_b [CH];
	logic [CNT_W-1:0] hold_c [CH];
	logic             was_on [CH];
	logic [REG_W-1:0] stair_t [CH];
	logic [REG_W-1:0] hold_on_t [CH];
	logic [REG_W-1:0] hold_off_t [CH];

	lamp_word_t lamps_due [$];
	int         bad_words = 0;
	int         ticks_sent = 0;
	int         cycle_count = 0;
	int         hold_off_reqs = 0;
	bit         sender_bursty = 1'b1;
	int         burst_left = 0;

	pushbutton_hold_light_controller_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick_valid     (tick_valid),
		.tick_ready     (tick_ready),
		.buttons        (buttons),
		.light_valid    (light_valid),
		.light_ready    (light_ready),
		.lights         (lights),
		.random_request (random_request),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial forever #5 clk = ~clk;

	function automatic logic [CH-1:0] key(input int ch);
		logic [CH-1:0] k;
		k = '0;
		k[ch] = 1'b1;
		return k;
	endfunction

	function automatic logic [REG_W-1:0] stair_len(input int ch);
		case (ch)
			0: return timing[REG_STAIR_CH0];
			2: return timing[REG_STAIR_CH2];
			default: return '0;
		endcase
	endfunction

	function automatic logic [REG_W-1:0] hold_on_len(input int ch);
		case (ch)
			0: return timing[REG_HOLD_ON_CH0];
			2: return timing[REG_HOLD_ON_CH2];
			default: return '0;
		endcase
	endfunction

	function automatic logic [REG_W-1:0] hold_off_len(input int ch);
		case (ch)
			1: return timing[REG_HOLD_OFF_CH1];
			3: return timing[REG_HOLD_OFF_CH3];
			default: return '0;
		endcase
	endfunction

	function automatic int hold_on_lamp(input int ch);
		case (ch)
			0: return 2;
			2: return 0;
			3: return 0;
			default: return NO_LAMP;
		endcase
	endfunction

	function automatic int hold_off_lamp(input int ch);
		case (ch)
			1: return 0;
			3: return 0;
			default: return NO_LAMP;
		endcase
	endfunction

	function automatic int drop_lamp(input int ch);
		case (ch)
			0: return 2;
			2: return 0;
			default: return NO_LAMP;
		endcase
	endfunction

	function automatic logic [REG_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return REG_W'($urandom_range(1, 3));
			3: return REG_W'($urandom_range(4, 94));
			4: return REG_W'($urandom_range(95, 100));
			5, 6: return REG_W'($urandom_range(101, 200));
			default: return REG_W'($urandom_range(201, 8191));
		endcase
	endfunction

	task automatic clear_model();
		timing[REG_STAIR_CH0]    = 13'd7000;
		timing[REG_STAIR_CH2]    = 13'd4000;
		timing[REG_HOLD_ON_CH0]  = 13'd5000;
		timing[REG_HOLD_ON_CH2]  = 13'd4000;
		timing[REG_HOLD_OFF_CH1] = 13'd4000;
		timing[REG_HOLD_OFF_CH3] = 13'd2000;
		lamp_q = '0;
		for (int ch = 0; ch < CH; ch++) begin
			hold_a[ch] = '0;
			hold_b[ch] = '0;
			hold_c[ch] = '0;
			was_on[ch] = 1'b0;
			stair_t[ch] = '0;
			hold_on_t[ch] = '0;
			hold_off_t[ch] = '0;
		end
	endtask

	task automatic set_lamp(input int lamp, input logic on);
		if (lamp >= 0)
			lamp_q[lamp] = on;
	endtask

	task automatic run_off_timer(input logic [REG_W-1:0] cnt, input logic [REG_W-1:0] period,
			input int lamp, output logic [REG_W-1:0] cnt_next);
		logic [REG_W:0] step;
		logic [REG_W:0] span;
		cnt_next = cnt;
		if (cnt != '0) begin
			step = {1'b0, cnt} + 1'b1;
			span = {1'b0, period};
			if (span >= WARN_OFF_BEFORE && step == span - WARN_OFF_BEFORE)
				set_lamp(lamp, 1'b0);
			if (span >= WARN_ON_BEFORE && step == span - WARN_ON_BEFORE)
				set_lamp(lamp, 1'b1);
			if (step >= span) begin
				set_lamp(lamp, 1'b0);
				step = '0;
			end
			cnt_next = step[REG_W-1:0];
		end
	endtask

	task automatic predict_lamps(input logic [CH-1:0] btn, output lamp_word_t word);
		logic req;
		logic on;
		req = 1'b0;
		for (int ch = 0; ch < CH; ch++) begin
			if (!btn[ch]) begin
				hold_a[ch] = '0;
				hold_b[ch] = '0;
				hold_c[ch] = '0;
			end else begin
				if (hold_a[ch] == '0) begin
					on = lamp_q[ch];
					hold_a[ch] = CNT_W'(1);
					hold_b[ch] = hold_b[ch] + 1'b1;
					hold_c[ch] = hold_c[ch] + 1'b1;
					was_on[ch] = on;
					if (on) begin
						stair_t[ch] = '0;
						lamp_q[ch] = 1'b0;
					end else begin
						if (stair_len(ch) != '0)
							stair_t[ch] = REG_W'(1);
						lamp_q[ch] = 1'b1;
					end
				end
				if (hold_a[ch] != '0)
					hold_a[ch] = hold_a[ch] + 1'b1;
				if (hold_a[ch] == SECOND_AT) begin
					if (!was_on[ch]) begin
						if (hold_on_len(ch) != '0) begin
							hold_on_t[ch] = REG_W'(1);
							stair_t[ch] = '0;
						end
						set_lamp(hold_on_lamp(ch), 1'b1);
					end else begin
						if (hold_off_lamp(ch) != NO_LAMP) begin
							if (hold_off_len(ch) != '0)
								hold_off_t[ch] = REG_W'(1);
							set_lamp(hold_off_lamp(ch), 1'b1);
						end
						if (drop_lamp(ch) != NO_LAMP) begin
							set_lamp(drop_lamp(ch), 1'b0);
							stair_t[ch] = '0;
						end
					end
					hold_a[ch] = hold_a[ch] + 1'b1;
				end
				if (hold_b[ch] != '0) begin
					hold_b[ch] = hold_b[ch] + 1'b1;
					if (hold_b[ch] == ALL_OFF_AT) begin
						lamp_q = '0;
						for (int j = 0; j < CH; j++)
							stair_t[j] = '0;
					end
				end
				if (hold_c[ch] != '0) begin
					hold_c[ch] = hold_c[ch] + 1'b1;
					if (hold_c[ch] == RANDOM_AT) begin
						hold_a[ch] = '0;
						hold_b[ch] = '0;
						hold_c[ch] = '0;
						req = 1'b1;
						stair_t[ch] = '0;
						lamp_q[0] = 1'b1;
						stair_t[0] = RANDOM_PRESET;
					end
				end
			end
		end
		for (int ch = 0; ch < CH; ch++)
			run_off_timer(stair_t[ch], stair_len(ch), ch, stair_t[ch]);
		for (int ch = 0; ch < CH; ch++)
			run_off_timer(hold_on_t[ch], hold_on_len(ch), hold_on_lamp(ch), hold_on_t[ch]);
		for (int ch = 0; ch < CH; ch++)
			run_off_timer(hold_off_t[ch], hold_off_len(ch), hold_off_lamp(ch), hold_off_t[ch]);
		word.lights = lamp_q;
		word.random_request = req;
	endtask

	task automatic send_tick(input logic [CH-1:0] btn);
		lamp_word_t word;
		if (sender_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				tick_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		tick_valid <= 1'b1;
		buttons <= btn;
		@(posedge clk);
		while (!tick_ready)
			@(posedge clk);
		predict_lamps(btn, word);
		lamps_due.push_back(word);
		ticks_sent++;
	endtask

	task automatic hold_keys(input logic [CH-1:0] mask, input int n);
		repeat (n) send_tick(mask);
	endtask

	task automatic rest_ticks(input int n);
		repeat (n) send_tick('0);
	endtask

	task automatic wait_drained();
		tick_valid <= 1'b0;
		while (lamps_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= REG_HOLD_OFF_CH3)
			timing[idx] = val;
	endtask

	task automatic set_timing(input logic [REG_W-1:0] st0, input logic [REG_W-1:0] st2,
			input logic [REG_W-1:0] on0, input logic [REG_W-1:0] on2,
			input logic [REG_W-1:0] off1, input logic [REG_W-1:0] off3);
		wait_drained();
		put_reg(REG_STAIR_CH0, st0);
		put_reg(REG_STAIR_CH2, st2);
		put_reg(REG_HOLD_ON_CH0, on0);
		put_reg(REG_HOLD_ON_CH2, on2);
		put_reg(REG_HOLD_OFF_CH1, off1);
		put_reg(REG_HOLD_OFF_CH3, off3);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic play_sequence();
		logic [CH-1:0] mask;
		logic [CH-1:0] noise;
		int            len;
		if ($urandom_range(0, 9) < 7) begin
			mask = key($urandom_range(0, CH - 1));
			if ($urandom_range(0, 4) == 0)
				mask = mask | key($urandom_range(0, CH - 1));
			case ($urandom_range(0, 5))
				0, 1: len = $urandom_range(1, 4);
				2, 3: len = $urandom_range(6, 10);
				4: len = $urandom_range(33, 37);
				default: len = $urandom_range(48, 53);
			endcase
			hold_keys(mask, len);
			rest_ticks($urandom_range(1, 12));
		end else begin
			repeat ($urandom_range(1, 8)) begin
				noise = CH'($urandom_range(0, 15));
				send_tick(noise);
			end
		end
	endtask

	task automatic test_short_presses();
		rest_ticks(1);
		for (int ch = 0; ch < CH; ch++) begin
			repeat (2) begin
				hold_keys(key(ch), 1);
				rest_ticks(1);
			end
		end
		hold_keys('1, 1);
		rest_ticks(1);
	endtask

	task automatic test_spare_index();
		set_timing(13'd30, 13'd4000, 13'd5000, 13'd4000, 13'd4000, 13'd2000);
		put_reg(IDX_SPARE_LO, '0);
		put_reg(IDX_SPARE_HI, '0);
		put_reg(IDX_SPARE_LO, '1);
		put_reg(IDX_SPARE_HI, '1);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (lamp_q[0])
			hold_keys(key(0), 1);
		rest_ticks(1);
		hold_keys(key(0), 1);
		rest_ticks(32);
	endtask

	task automatic test_second_actions();
		int   ch;
		logic want_on;
		repeat (2) begin
			set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
			repeat (6) begin
				ch = $urandom_range(0, CH - 1);
				want_on = 1'($urandom_range(0, 1));
				if (lamp_q[ch] != want_on) begin
					hold_keys(key(ch), 1);
					rest_ticks(1);
				end
				hold_keys(key(ch), $urandom_range(6, 9));
				rest_ticks($urandom_range(1, 6));
			end
		end
	endtask

	task automatic test_timer_edges();
		set_timing(REG_W'($urandom_range(94, 130)), REG_W'($urandom_range(94, 130)),
			REG_W'($urandom_range(94, 130)), REG_W'($urandom_range(94, 130)),
			REG_W'($urandom_range(94, 130)), REG_W'($urandom_range(94, 130)));
		if (lamp_q[2])
			hold_keys(key(2), 1);
		rest_ticks(1);
		hold_keys(key(2), 1);
		rest_ticks(1);
		if (lamp_q[0]) begin
			hold_keys(key(0), 1);
			rest_ticks(1);
		end
		hold_keys(key(0), 8);
		rest_ticks(1);
		if (!lamp_q[3]) begin
			hold_keys(key(3), 1);
			rest_ticks(1);
		end
		hold_keys(key(3), 8);
		rest_ticks(1);
		if (!lamp_q[1]) begin
			hold_keys(key(1), 1);
			rest_ticks(1);
		end
		hold_keys(key(1), 8);
		rest_ticks(135);
	endtask

	task automatic test_all_off_hold();
		repeat (2) begin
			hold_keys('1, 1);
			rest_ticks(1);
			hold_keys(key($urandom_range(0, CH - 1)), $urandom_range(33, 36));
			rest_ticks(2);
		end
	endtask

	task automatic test_random_mode_hold();
		set_timing('1, pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
		hold_keys(key($urandom_range(0, CH - 1)), $urandom_range(49, 52));
		rest_ticks(2);
		set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
		hold_keys(key($urandom_range(0, CH - 1)) | key($urandom_range(0, CH - 1)),
			$urandom_range(49, 52));
		rest_ticks(2);
	endtask

	task automatic test_register_bounds();
		set_timing('0, '0, '0, '0, '0, '0);
		repeat (3) play_sequence();
		set_timing('1, '1, '1, '1, '1, '1);
		repeat (3) play_sequence();
	endtask

	task automatic test_back_pressure();
		logic [CH-1:0] noise;
		sender_bursty = 1'b0;
		wait_drained();
		hold_off_reqs <= hold_off_reqs + 1;
		repeat (40) begin
			noise = CH'($urandom_range(0, 15));
			send_tick(noise);
		end
		wait_drained();
		sender_bursty = 1'b1;
	endtask

	task automatic test_random_mix();
		while (ticks_sent < TICK_GOAL) begin
			set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
			sender_bursty = $urandom_range(0, 3) != 0;
			repeat (6) play_sequence();
		end
		sender_bursty = 1'b1;
	endtask

	initial begin
		int seg_left;
		int stall_pct;
		int hold_off_seen;
		seg_left = 0;
		stall_pct = 0;
		hold_off_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_off_reqs != hold_off_seen) begin
				hold_off_seen = hold_off_reqs;
				light_ready <= 1'b0;
				repeat (LONG_HOLD_OFF) @(posedge clk);
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			seg_left--;
			light_ready <= ($urandom_range(1, 100) > stall_pct);
		end
	end

	initial begin
		lamp_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && light_valid && light_ready) begin
				if (lamps_due.size() == 0) begin
					bad_words++;
					$display("%0t: light word with none due: expected none actual %h/%b",
						$time, lights, random_request);
				end else begin
					want = lamps_due.pop_front();
					if (lights !== want.lights) begin
						bad_words++;
						$display("%0t: lights mismatch: expected %h actual %h",
							$time, want.lights, lights);
					end
					if (random_request !== want.random_request) begin
						bad_words++;
						$display("%0t: random_request mismatch: expected %b actual %b",
							$time, want.random_request, random_request);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clear_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_short_presses();
		test_spare_index();
		test_second_actions();
		test_timer_edges();
		test_all_off_hold();
		test_random_mode_hold();
		test_register_bounds();
		test_back_pressure();
		test_random_mix();
		wait_drained();
		if (bad_words == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/phlc_pkg.sv
src/phlc_tick.sv
src/pushbutton_hold_light_controller_core.sv
sim/tb_top.sv
